/* hdl/dss_pkg.sv */
// -----------------------------------------------------------------------------
// Dual stepper sequencer package
// Shared widths, input modes, the half-step coil table and the result layout.
// -----------------------------------------------------------------------------
package dss_pkg;

   // Width of the countdown and step counters (valid range 8 to 32)
   localparam int COUNT_WIDTH = 16;
   localparam int FIELD_WIDTH = 16;
   localparam int WIDE_WIDTH  = (COUNT_WIDTH > FIELD_WIDTH) ? COUNT_WIDTH : FIELD_WIDTH;
   localparam int PHASE_WIDTH = 3;
   localparam int COIL_WIDTH  = 4;
   localparam int NUM_MOTORS  = 2;
   localparam int MOTOR_A     = 0;
   localparam int MOTOR_B     = 1;

   localparam logic [COUNT_WIDTH-1:0] RESET_COUNTDOWN = COUNT_WIDTH'(100);
   localparam logic [COUNT_WIDTH-1:0] LOAD_COUNTDOWN  = COUNT_WIDTH'(1);

   typedef enum logic [1:0] {
      MODE_TICK   = 2'd0,
      MODE_LOAD   = 2'd1,
      MODE_STOP_A = 2'd2,
      MODE_STOP_B = 2'd3
   } mode_type;

   typedef logic [COUNT_WIDTH-1:0] count_type;

   typedef struct packed {
      logic [COIL_WIDTH-1:0]  coils_a;
      logic [COIL_WIDTH-1:0]  coils_b;
      logic                   stepped_a;
      logic                   stepped_b;
      logic [FIELD_WIDTH-1:0] steps_left_a;
      logic [FIELD_WIDTH-1:0] steps_left_b;
   } result_type;

   // Half-step pattern: bit0 orange, bit1 yellow, bit2 pink, bit3 blue
   function automatic logic [COIL_WIDTH-1:0] phase_pattern(input logic [PHASE_WIDTH-1:0] idx);
      logic [COIL_WIDTH-1:0] pat;
      case (idx)
         3'd0:    pat = 4'h8;
         3'd1:    pat = 4'hC;
         3'd2:    pat = 4'h4;
         3'd3:    pat = 4'h6;
         3'd4:    pat = 4'h2;
         3'd5:    pat = 4'h3;
         3'd6:    pat = 4'h1;
         default: pat = 4'h9;
      endcase
      return pat;
   endfunction

   // Widen or trim a 16-bit input field to counter width
   function automatic count_type field_to_count(input logic [FIELD_WIDTH-1:0] field);
      logic [WIDE_WIDTH-1:0] wide;
      wide = WIDE_WIDTH'(field);
      return wide[COUNT_WIDTH-1:0];
   endfunction

   // Low 16 bits of a counter for the result fields
   function automatic logic [FIELD_WIDTH-1:0] count_to_field(input count_type count);
      logic [WIDE_WIDTH-1:0] wide;
      wide = WIDE_WIDTH'(count);
      return wide[FIELD_WIDTH-1:0];
   endfunction

endpackage

/* hdl/dual_stepper_half_step_sequencer.sv */
// -----------------------------------------------------------------------------
// Dual stepper half-step sequencer
// Drives two unipolar steppers in eight-phase half-step from tick, load and
// end-stop transactions.
// -----------------------------------------------------------------------------
// Usage:
//   req_* channel: one transaction per item; req_mode selects tick, load of
//   both motors, or end-stop of motor a or b. The step/period/direction fields
//   are used only by a load.
//   rsp_* channel: exactly one result per request, in order: coil drive of
//   both motors, a stepped flag for each, and the steps left after the item.
//   Result: registered in the result register, or parked in the skid while stalled.
//   Throughput: one transaction per cycle while req_ready is high; the motor
//   state updates in a single pass of logic from request to result register.
//   Stall: a skid register holds one extra result while rsp_ready is low, so
//   req_ready drops only once both the result register and the skid are full;
//   req_ready is driven by a register alone.
//   Reset: countdowns go to 100, steps, periods, phases and coils to zero,
//   move flags clear, and both result stages empty.
// -----------------------------------------------------------------------------
module dual_stepper_half_step_sequencer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [15:0] req_steps_a,
   input  logic [15:0] req_period_a,
   input  logic        req_direction_a,
   input  logic [15:0] req_steps_b,
   input  logic [15:0] req_period_b,
   input  logic        req_direction_b,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_coils_a,
   output logic [3:0]  rsp_coils_b,
   output logic        rsp_stepped_a,
   output logic        rsp_stepped_b,
   output logic [15:0] rsp_steps_left_a,
   output logic [15:0] rsp_steps_left_b
);

   localparam int NM = dss_pkg::NUM_MOTORS;
   localparam int PW = dss_pkg::PHASE_WIDTH;
   localparam int CW = dss_pkg::COIL_WIDTH;

   // Motor state
   dss_pkg::count_type countdown_ff [NM];
   dss_pkg::count_type countdown_in [NM];
   logic               pending_ff   [NM];
   logic               pending_in   [NM];
   dss_pkg::count_type steps_ff     [NM];
   dss_pkg::count_type steps_in     [NM];
   dss_pkg::count_type period_ff    [NM];
   dss_pkg::count_type period_in    [NM];
   logic               dir_ff       [NM];
   logic               dir_in       [NM];
   logic [PW-1:0]      phase_ff     [NM];
   logic [PW-1:0]      phase_in     [NM];
   logic [CW-1:0]      coil_ff      [NM];
   logic [CW-1:0]      coil_in      [NM];

   // Load fields and step flags per motor
   dss_pkg::count_type load_steps  [NM];
   dss_pkg::count_type load_period [NM];
   logic               load_dir    [NM];
   logic               stepped     [NM];
   dss_pkg::count_type dec_count   [NM];

   // Result register and skid
   dss_pkg::result_type result;
   dss_pkg::result_type main_ff, main_in;
   dss_pkg::result_type skid_ff, skid_in;
   logic                main_valid_ff, main_valid_in;
   logic                skid_valid_ff, skid_valid_in;
   logic                accept;
   logic                drain;
   dss_pkg::mode_type   mode;

   assign req_ready = ~skid_valid_ff;
   assign accept    = req_valid & req_ready;
   assign drain     = rsp_ready | ~main_valid_ff;
   assign mode      = dss_pkg::mode_type'(req_mode);

   assign load_steps[dss_pkg::MOTOR_A]  = dss_pkg::field_to_count(req_steps_a);
   assign load_steps[dss_pkg::MOTOR_B]  = dss_pkg::field_to_count(req_steps_b);
   assign load_period[dss_pkg::MOTOR_A] = dss_pkg::field_to_count(req_period_a);
   assign load_period[dss_pkg::MOTOR_B] = dss_pkg::field_to_count(req_period_b);
   assign load_dir[dss_pkg::MOTOR_A]    = req_direction_a;
   assign load_dir[dss_pkg::MOTOR_B]    = req_direction_b;

   always_comb begin
      for (int m = 0; m < NM; m++) begin
         countdown_in[m] = countdown_ff[m];
         pending_in[m]   = pending_ff[m];
         steps_in[m]     = steps_ff[m];
         period_in[m]    = period_ff[m];
         dir_in[m]       = dir_ff[m];
         phase_in[m]     = phase_ff[m];
         coil_in[m]      = coil_ff[m];
         stepped[m]      = 1'b0;
         dec_count[m]    = countdown_ff[m] - dss_pkg::COUNT_WIDTH'(1);
         unique case (mode)
            dss_pkg::MODE_TICK: begin
               countdown_in[m] = dec_count[m];
               if ((steps_ff[m] != '0) && pending_ff[m]) begin
                  stepped[m]    = 1'b1;
                  coil_in[m]    = dss_pkg::phase_pattern(phase_ff[m]);
                  phase_in[m]   = dir_ff[m] ? phase_ff[m] + PW'(1) : phase_ff[m] - PW'(1);
                  steps_in[m]   = steps_ff[m] - dss_pkg::COUNT_WIDTH'(1);
                  pending_in[m] = 1'b0;
               end
               // reload and arm the next step
               if (dec_count[m] == '0) begin
                  countdown_in[m] = period_ff[m];
                  pending_in[m]   = 1'b1;
               end
            end
            dss_pkg::MODE_LOAD: begin
               steps_in[m]     = load_steps[m];
               period_in[m]    = load_period[m];
               dir_in[m]       = load_dir[m];
               countdown_in[m] = dss_pkg::LOAD_COUNTDOWN;
               pending_in[m]   = 1'b0;
            end
            dss_pkg::MODE_STOP_A: begin
               if (m == dss_pkg::MOTOR_A) steps_in[m] = '0;
            end
            dss_pkg::MODE_STOP_B: begin
               if (m == dss_pkg::MOTOR_B) steps_in[m] = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      result.coils_a      = coil_in[dss_pkg::MOTOR_A];
      result.coils_b      = coil_in[dss_pkg::MOTOR_B];
      result.stepped_a    = stepped[dss_pkg::MOTOR_A];
      result.stepped_b    = stepped[dss_pkg::MOTOR_B];
      result.steps_left_a = dss_pkg::count_to_field(steps_in[dss_pkg::MOTOR_A]);
      result.steps_left_b = dss_pkg::count_to_field(steps_in[dss_pkg::MOTOR_B]);
   end

   // Output register with one-entry skid
   always_comb begin
      main_in       = main_ff;
      main_valid_in = main_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (drain) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = result;
            main_valid_in = accept;
         end
      end else if (accept) begin
         // hold the stalled result, park the new one
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
         for (int m = 0; m < NM; m++) begin
            countdown_ff[m] <= dss_pkg::RESET_COUNTDOWN;
            pending_ff[m]   <= 1'b0;
            steps_ff[m]     <= '0;
            period_ff[m]    <= '0;
            dir_ff[m]       <= 1'b0;
            phase_ff[m]     <= '0;
            coil_ff[m]      <= '0;
         end
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
         if (accept) begin
            for (int m = 0; m < NM; m++) begin
               countdown_ff[m] <= countdown_in[m];
               pending_ff[m]   <= pending_in[m];
               steps_ff[m]     <= steps_in[m];
               period_ff[m]    <= period_in[m];
               dir_ff[m]       <= dir_in[m];
               phase_ff[m]     <= phase_in[m];
               coil_ff[m]      <= coil_in[m];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid        = main_valid_ff;
   assign rsp_coils_a      = main_ff.coils_a;
   assign rsp_coils_b      = main_ff.coils_b;
   assign rsp_stepped_a    = main_ff.stepped_a;
   assign rsp_stepped_b    = main_ff.stepped_b;
   assign rsp_steps_left_a = main_ff.steps_left_a;
   assign rsp_steps_left_b = main_ff.steps_left_b;

endmodule

/* hdl/dss_checker.sv */
// -----------------------------------------------------------------------------
// Dual stepper sequencer port checker
// Watches the top-level ports for stall behavior, reset, results after accepts and coil patterns.
// -----------------------------------------------------------------------------
module dss_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  rsp_coils_a,
   input logic [3:0]  rsp_coils_b,
   input logic        rsp_stepped_a,
   input logic        rsp_stepped_b,
   input logic [15:0] rsp_steps_left_a,
   input logic [15:0] rsp_steps_left_b
);

   // Hold a stalled result unchanged
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_coils_a) && $stable(rsp_coils_b)
         && $stable(rsp_steps_left_a) && $stable(rsp_steps_left_b))
      else $error("stalled result changed");

   // Drop all results on reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // An accepted transaction leaves a result waiting on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted transaction produced no result");

   // A step of motor a always energizes at least one coil
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stepped_a |-> rsp_coils_a != 4'h0)
      else $error("motor a stepped with all coils off");

   // Motor b shows only half-step patterns or all off
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_coils_b == 4'h0 || rsp_coils_b == 4'h8 || rsp_coils_b == 4'hC
         || rsp_coils_b == 4'h4 || rsp_coils_b == 4'h6 || rsp_coils_b == 4'h2
         || rsp_coils_b == 4'h3 || rsp_coils_b == 4'h1 || rsp_coils_b == 4'h9))
      else $error("motor b coil pattern not in half-step sequence");

endmodule

bind dual_stepper_half_step_sequencer dss_checker u_dss_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_coils_a      (rsp_coils_a),
   .rsp_coils_b      (rsp_coils_b),
   .rsp_stepped_a    (rsp_stepped_a),
   .rsp_stepped_b    (rsp_stepped_b),
   .rsp_steps_left_a (rsp_steps_left_a),
   .rsp_steps_left_b (rsp_steps_left_b)
);

/* sim/dss_step_checker.sv */
// -----------------------------------------------------------------------------
// Dual stepper sequencer checker
// Watches the request and result channels of the sequencer, keeps its own
// model of both motors, predicts one result per accepted request and compares
// each accepted result field by field with the oldest prediction.
// -----------------------------------------------------------------------------
module dss_step_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [15:0] req_steps_a,
   input  logic [15:0] req_period_a,
   input  logic        req_direction_a,
   input  logic [15:0] req_steps_b,
   input  logic [15:0] req_period_b,
   input  logic        req_direction_b,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [3:0]  rsp_coils_a,
   input  logic [3:0]  rsp_coils_b,
   input  logic        rsp_stepped_a,
   input  logic        rsp_stepped_b,
   input  logic [15:0] rsp_steps_left_a,
   input  logic [15:0] rsp_steps_left_b,
   output int          errors,
   output int          outstanding,
   output int          checked,
   output int          steps_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   // Half-step coil sequence, phase i in nibble i
   localparam logic [31:0] HALF_STEP_SEQ = 32'h9132_64C8;

   dss_pkg::count_type countdown_r [dss_pkg::NUM_MOTORS];
   logic               pending_r   [dss_pkg::NUM_MOTORS];
   dss_pkg::count_type steps_r     [dss_pkg::NUM_MOTORS];
   dss_pkg::count_type period_r    [dss_pkg::NUM_MOTORS];
   logic               dir_r       [dss_pkg::NUM_MOTORS];
   logic [2:0]         phase_r     [dss_pkg::NUM_MOTORS];
   logic [3:0]         coils_r     [dss_pkg::NUM_MOTORS];

   dss_pkg::result_type awaited_outputs [$];
   dss_pkg::result_type due;

   function automatic void reset_motors();
      int m;
      for (m = 0; m < dss_pkg::NUM_MOTORS; m++) begin
         countdown_r[m] = dss_pkg::RESET_COUNTDOWN;
         pending_r[m]   = 1'b0;
         steps_r[m]     = '0;
         period_r[m]    = '0;
         dir_r[m]       = 1'b0;
         phase_r[m]     = '0;
         coils_r[m]     = '0;
      end
   endfunction

   function automatic logic tick_motor(int m);
      logic took;
      took = 1'b0;
      countdown_r[m] = countdown_r[m] - 1'b1;
      if (steps_r[m] != '0 && pending_r[m]) begin
         coils_r[m]   = HALF_STEP_SEQ[phase_r[m]*4 +: 4];
         phase_r[m]   = dir_r[m] ? phase_r[m] + 3'd1 : phase_r[m] - 3'd1;
         steps_r[m]   = steps_r[m] - 1'b1;
         pending_r[m] = 1'b0;
         took         = 1'b1;
      end
      // Reload after the step decision, so a fresh flag waits for the next tick
      if (countdown_r[m] == '0) begin
         countdown_r[m] = period_r[m];
         pending_r[m]   = 1'b1;
      end
      return took;
   endfunction

   function automatic dss_pkg::result_type predict_outputs(
      dss_pkg::mode_type mode,
      logic [15:0] sa, logic [15:0] pa, logic da,
      logic [15:0] sb, logic [15:0] pb, logic db);
      dss_pkg::result_type r;
      logic [1:0] took;
      int         m;
      took = '0;
      case (mode)
         dss_pkg::MODE_TICK: begin
            for (m = 0; m < dss_pkg::NUM_MOTORS; m++) took[m] = tick_motor(m);
         end
         dss_pkg::MODE_LOAD: begin
            steps_r[dss_pkg::MOTOR_A]  = dss_pkg::count_type'(sa);
            period_r[dss_pkg::MOTOR_A] = dss_pkg::count_type'(pa);
            dir_r[dss_pkg::MOTOR_A]    = da;
            steps_r[dss_pkg::MOTOR_B]  = dss_pkg::count_type'(sb);
            period_r[dss_pkg::MOTOR_B] = dss_pkg::count_type'(pb);
            dir_r[dss_pkg::MOTOR_B]    = db;
            for (m = 0; m < dss_pkg::NUM_MOTORS; m++) begin
               countdown_r[m] = dss_pkg::LOAD_COUNTDOWN;
               pending_r[m]   = 1'b0;
            end
         end
         dss_pkg::MODE_STOP_A: steps_r[dss_pkg::MOTOR_A] = '0;
         default:              steps_r[dss_pkg::MOTOR_B] = '0;
      endcase
      r.coils_a      = coils_r[dss_pkg::MOTOR_A];
      r.coils_b      = coils_r[dss_pkg::MOTOR_B];
      r.stepped_a    = took[dss_pkg::MOTOR_A];
      r.stepped_b    = took[dss_pkg::MOTOR_B];
      r.steps_left_a = dss_pkg::FIELD_WIDTH'(steps_r[dss_pkg::MOTOR_A]);
      r.steps_left_b = dss_pkg::FIELD_WIDTH'(steps_r[dss_pkg::MOTOR_B]);
      return r;
   endfunction

   task automatic compare_field(string field, logic [15:0] expected, logic [15:0] actual);
      if (expected !== actual) begin
         $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h",
                  $time, field, expected, actual);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         reset_motors();
         awaited_outputs.delete();
         errors     = 0;
         checked    = 0;
         steps_seen = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_outputs.size() == 0) begin
               $display("%0t ns: result transaction with no request waiting, expected none, "
                        , $time, "got coils_a 0x%0h coils_b 0x%0h", rsp_coils_a, rsp_coils_b);
               errors++;
            end else begin
               due = awaited_outputs.pop_front();
               compare_field("coils_a",      16'(due.coils_a),   16'(rsp_coils_a));
               compare_field("coils_b",      16'(due.coils_b),   16'(rsp_coils_b));
               compare_field("stepped_a",    16'(due.stepped_a), 16'(rsp_stepped_a));
               compare_field("stepped_b",    16'(due.stepped_b), 16'(rsp_stepped_b));
               compare_field("steps_left_a", due.steps_left_a,   rsp_steps_left_a);
               compare_field("steps_left_b", due.steps_left_b,   rsp_steps_left_b);
               checked++;
               steps_seen += int'(rsp_stepped_a === 1'b1) + int'(rsp_stepped_b === 1'b1);
            end
         end
         if (req_valid && req_ready)
            awaited_outputs.push_back(predict_outputs(dss_pkg::mode_type'(req_mode),
               req_steps_a, req_period_a, req_direction_a,
               req_steps_b, req_period_b, req_direction_b));
      end
      outstanding <= awaited_outputs.size();
   end

endmodule

/* sim/tb_dual_stepper_half_step_sequencer.sv */
// -----------------------------------------------------------------------------
// Dual stepper sequencer testbench
// Drives tick, load and end-stop transactions into the sequencer with random
// gaps and result back-pressure; a checker beside the block predicts and
// compares every result, and this top reports the verdict.
// -----------------------------------------------------------------------------
module tb_dual_stepper_half_step_sequencer;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 950;
   localparam int CYCLE_LIMIT  = 300000;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_mode;
   logic [15:0] req_steps_a;
   logic [15:0] req_period_a;
   logic        req_direction_a;
   logic [15:0] req_steps_b;
   logic [15:0] req_period_b;
   logic        req_direction_b;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [3:0]  rsp_coils_a;
   logic [3:0]  rsp_coils_b;
   logic        rsp_stepped_a;
   logic        rsp_stepped_b;
   logic [15:0] rsp_steps_left_a;
   logic [15:0] rsp_steps_left_b;

   int errors;
   int outstanding;
   int checked;
   int steps_seen;

   int gap_pct   = 0;
   int stall_pct = 0;
   int rsp_hold  = 0;
   bit calm      = 1'b0;
   int cycles    = 0;
   int sent_total, sent_ticks, sent_loads, sent_stops;

   always #5ns clock = ~clock;

   dual_stepper_half_step_sequencer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_steps_a      (req_steps_a),
      .req_period_a     (req_period_a),
      .req_direction_a  (req_direction_a),
      .req_steps_b      (req_steps_b),
      .req_period_b     (req_period_b),
      .req_direction_b  (req_direction_b),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_coils_a      (rsp_coils_a),
      .rsp_coils_b      (rsp_coils_b),
      .rsp_stepped_a    (rsp_stepped_a),
      .rsp_stepped_b    (rsp_stepped_b),
      .rsp_steps_left_a (rsp_steps_left_a),
      .rsp_steps_left_b (rsp_steps_left_b)
   );

   dss_step_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_steps_a      (req_steps_a),
      .req_period_a     (req_period_a),
      .req_direction_a  (req_direction_a),
      .req_steps_b      (req_steps_b),
      .req_period_b     (req_period_b),
      .req_direction_b  (req_direction_b),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_coils_a      (rsp_coils_a),
      .rsp_coils_b      (rsp_coils_b),
      .rsp_stepped_a    (rsp_stepped_a),
      .rsp_stepped_b    (rsp_stepped_b),
      .rsp_steps_left_a (rsp_steps_left_a),
      .rsp_steps_left_b (rsp_steps_left_b),
      .errors           (errors),
      .outstanding      (outstanding),
      .checked          (checked),
      .steps_seen       (steps_seen)
   );

   // Result back-pressure: random stall bursts of random length
   always @(posedge clock) begin
      if (rsp_hold > 0)
         rsp_hold--;
      else if (!calm && $urandom_range(0, 99) < stall_pct)
         rsp_hold = $urandom_range(1, 8);
      rsp_ready <= (rsp_hold == 0);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding", cycles, outstanding);
         $display("dual_stepper_half_step_sequencer verification failed");
         $finish;
      end
   end

   // Mostly small counts, with full-range values and extremes mixed in
   function automatic logic [15:0] pick_count(int small_hi);
      int r;
      r = $urandom_range(0, 99);
      if (r < 65)
         return 16'($urandom_range(0, small_hi));
      else if (r < 90)
         return 16'($urandom);
      else if (r < 95)
         return 16'hFFFF;
      return 16'h0000;
   endfunction

   task automatic send_item(dss_pkg::mode_type mode,
                            logic [15:0] sa, logic [15:0] pa, logic da,
                            logic [15:0] sb, logic [15:0] pb, logic db);
      if (!calm && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= mode;
      req_steps_a     <= sa;
      req_period_a    <= pa;
      req_direction_a <= da;
      req_steps_b     <= sb;
      req_period_b    <= pb;
      req_direction_b <= db;
      do @(posedge clock); while (!req_ready);
      sent_total++;
      case (mode)
         dss_pkg::MODE_TICK: sent_ticks++;
         dss_pkg::MODE_LOAD: sent_loads++;
         default:            sent_stops++;
      endcase
   endtask

   // Payload fields are don't-care outside a load; fill them with noise
   task automatic send_simple(dss_pkg::mode_type mode);
      send_item(mode, 16'($urandom), 16'($urandom), 1'($urandom),
                16'($urandom), 16'($urandom), 1'($urandom));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   initial begin
      int  target;
      int  r;
      bit  pressed;
      pressed = 1'b0;

      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_mode        <= dss_pkg::MODE_TICK;
      req_steps_a     <= '0;
      req_period_a    <= '0;
      req_direction_a <= 1'b0;
      req_steps_b     <= '0;
      req_period_b    <= '0;
      req_direction_b <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Idle motors: nothing should move or change
      send_simple(dss_pkg::MODE_TICK);
      send_simple(dss_pkg::MODE_STOP_A);
      send_simple(dss_pkg::MODE_STOP_B);
      // Short period forward on a, full-range counts in reverse on b
      send_item(dss_pkg::MODE_LOAD, 16'd3, 16'd1, 1'b1, 16'hFFFF, 16'hFFFF, 1'b0);
      repeat (4) send_simple(dss_pkg::MODE_TICK);
      // Period zero on a wraps the countdown after its first step
      send_item(dss_pkg::MODE_LOAD, 16'd2, 16'd0, 1'b0, 16'd5, 16'd2, 1'b1);
      repeat (3) send_simple(dss_pkg::MODE_TICK);
      // End-stops in the middle of a move
      send_simple(dss_pkg::MODE_STOP_A);
      send_simple(dss_pkg::MODE_TICK);
      send_simple(dss_pkg::MODE_STOP_B);
      send_simple(dss_pkg::MODE_TICK);
      // All-ones load followed by all-zeros load
      send_item(dss_pkg::MODE_LOAD, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1);
      send_item(dss_pkg::MODE_LOAD, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000, 1'b0);
      send_simple(dss_pkg::MODE_TICK);

      target = sent_total + RANDOM_ITEMS;
      while (sent_total < target) begin
         if (sent_total > target - RANDOM_ITEMS / 8)
            calm = 1'b1;
         if ($urandom_range(0, 7) == 0) begin
            r = $urandom_range(0, 4);
            gap_pct = (r < 2) ? 0 : (r == 2) ? 10 : (r == 3) ? 30 : 60;
            r = $urandom_range(0, 4);
            stall_pct = (r < 2) ? 0 : (r == 2) ? 10 : (r == 3) ? 30 : 60;
         end
         // Hold the sender once until every result is back
         if (!pressed && sent_total > target - RANDOM_ITEMS / 2) begin
            drain_results();
            pressed = 1'b1;
         end
         if ($urandom_range(0, 99) < 85) begin
            send_item(dss_pkg::MODE_LOAD, pick_count(30), pick_count(6), 1'($urandom),
                      pick_count(30), pick_count(6), 1'($urandom));
            repeat ($urandom_range(4, 40)) begin
               r = $urandom_range(0, 99);
               if (r < 3)
                  send_simple(dss_pkg::MODE_STOP_A);
               else if (r < 6)
                  send_simple(dss_pkg::MODE_STOP_B);
               else
                  send_simple(dss_pkg::MODE_TICK);
            end
         end else begin
            repeat ($urandom_range(1, 6))
               send_item(dss_pkg::mode_type'($urandom_range(0, 3)), 16'($urandom),
                         16'($urandom), 1'($urandom), 16'($urandom), 16'($urandom),
                         1'($urandom));
         end
      end

      drain_results();
      repeat (5) @(posedge clock);

      $display("Sent %0d ticks, %0d loads and %0d end-stops with random gaps and stalls;",
               sent_ticks, sent_loads, sent_stops);
      $display("checked %0d results covering %0d motor steps.", checked, steps_seen);
      if (errors == 0)
         $display("dual_stepper_half_step_sequencer verification clean");
      else
         $display("dual_stepper_half_step_sequencer verification failed");
      $finish;
   end

endmodule

/* sim.f */
hdl/dss_pkg.sv
hdl/dual_stepper_half_step_sequencer.sv
hdl/dss_checker.sv
sim/dss_step_checker.sv
sim/tb_dual_stepper_half_step_sequencer.sv
